[rtl/core/gbsc_pkg.sv]
// shared types, constants and the eight-bit-wide grain v1 update function
package gbsc_pkg;

    localparam int KEY_BITS    = 80;
    localparam int IV_BITS     = 64;
    localparam int INIT_ROUNDS = 160;
    localparam int BYTE_BITS   = 8;

    // initialization runs eight register clocks per cycle
    localparam int INIT_STEPS = INIT_ROUNDS / BYTE_BITS;
    localparam int ROUND_W    = $clog2(INIT_STEPS);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_LOW  = 2'd0,
        CFG_KEY_HIGH = 2'd1,
        CFG_IV_VALUE = 2'd2
    } t_cfg_index;

    // one queued transaction, tagged by whether it starts or ends a message stream
    typedef struct packed {
        logic [BYTE_BITS-1:0] data;
        logic                 restart;
        logic                 last;
    } t_job;

    // key and iv as the engine sees them
    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [IV_BITS-1:0]  iv;
    } t_cfg;

    // result of eight register clocks
    typedef struct packed {
        logic [KEY_BITS-1:0]  nfsr;
        logic [KEY_BITS-1:0]  lfsr;
        logic [BYTE_BITS-1:0] ks;
    } t_step8;

    // eight steps at once: every tap of step i sits at most seven places
    // above its single-step position and below 72, so all eight lanes read the
    // current state only; bit i of ks is the keystream bit of step i
    function automatic t_step8 grain_step8(
        input logic [KEY_BITS-1:0] b,
        input logic [KEY_BITS-1:0] s,
        input logic                init_mode
    );
        t_step8               res;
        logic [BYTE_BITS-1:0] z;
        logic [BYTE_BITS-1:0] nb;
        logic [BYTE_BITS-1:0] lb;
        logic                 x0, x1, x2, x3, x4;
        for (int i = 0; i < BYTE_BITS; i++) begin
            x0 = s[3+i];
            x1 = s[25+i];
            x2 = s[46+i];
            x3 = s[64+i];
            x4 = b[63+i];
            z[i] = b[1+i] ^ b[2+i] ^ b[4+i] ^ b[10+i] ^ b[31+i] ^ b[43+i] ^ b[56+i]
                 ^ x1 ^ x4 ^ (x0 & x3) ^ (x2 & x3) ^ (x3 & x4)
                 ^ (x0 & x1 & x2) ^ (x0 & x2 & x3) ^ (x0 & x2 & x4)
                 ^ (x1 & x2 & x4) ^ (x2 & x3 & x4);
            nb[i] = s[0+i] ^ b[62+i] ^ b[60+i] ^ b[52+i] ^ b[45+i] ^ b[37+i]
                  ^ b[33+i] ^ b[28+i] ^ b[21+i] ^ b[14+i] ^ b[9+i] ^ b[0+i]
                  ^ (b[63+i] & b[60+i]) ^ (b[37+i] & b[33+i]) ^ (b[15+i] & b[9+i])
                  ^ (b[60+i] & b[52+i] & b[45+i]) ^ (b[33+i] & b[28+i] & b[21+i])
                  ^ (b[63+i] & b[45+i] & b[28+i] & b[9+i])
                  ^ (b[60+i] & b[52+i] & b[37+i] & b[33+i])
                  ^ (b[63+i] & b[60+i] & b[21+i] & b[15+i])
                  ^ (b[63+i] & b[60+i] & b[52+i] & b[45+i] & b[37+i])
                  ^ (b[33+i] & b[28+i] & b[21+i] & b[15+i] & b[9+i])
                  ^ (b[52+i] & b[45+i] & b[37+i] & b[33+i] & b[28+i] & b[21+i]);
            lb[i] = s[0+i] ^ s[13+i] ^ s[23+i] ^ s[38+i] ^ s[51+i] ^ s[62+i];
            if (init_mode) begin
                nb[i] = nb[i] ^ z[i];
                lb[i] = lb[i] ^ z[i];
            end
        end
        // shift by eight, new bits enter at the top, first one lowest
        res.nfsr = {nb, b[KEY_BITS-1:BYTE_BITS]};
        res.lfsr = {lb, s[KEY_BITS-1:BYTE_BITS]};
        res.ks   = z;
        return res;
    endfunction

endpackage

[rtl/core/gbsc_front.sv]
// input side: accepts transactions and queues them as jobs for the engine
module gbsc_front import gbsc_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [BYTE_BITS-1:0] i_data_in,
    input  logic                 i_restart,
    input  logic                 i_in_last,
    output logic                 o_job_valid,
    output t_job                 o_job,
    input  logic                 i_job_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             full;
    logic             push;
    logic             pop;
    t_job             job_in;

    assign full       = (r_count == CNT_W'(QUEUE_DEPTH));
    assign push       = i_in_valid && !full;
    assign pop        = i_job_pop && (r_count != '0);
    assign o_in_stall = full;

    // tag the transaction with its kind on entry
    always_comb begin
        job_in.data    = i_data_in;
        job_in.restart = i_restart;
        job_in.last    = i_in_last;
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= job_in;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_job_valid = (r_count != '0);
    assign o_job       = r_mem[r_rd_ptr];

endmodule

[rtl/core/gbsc_back.sv]
// cipher engine: reload, initialization run and one keystream byte per job
module gbsc_back import gbsc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_job_valid,
    input  t_job                 i_job,
    output logic                 o_job_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [BYTE_BITS-1:0] o_data_out,
    output logic                 o_out_last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_EMIT
    } t_state;

    localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(INIT_STEPS - 1);

    t_state               r_state, n_state;
    logic [KEY_BITS-1:0]  r_nfsr, n_nfsr;
    logic [KEY_BITS-1:0]  r_lfsr, n_lfsr;
    logic [ROUND_W-1:0]   r_round, n_round;
    logic                 r_out_valid, n_out_valid;
    logic [BYTE_BITS-1:0] r_out_data, n_out_data;
    logic                 r_out_last, n_out_last;
    logic                 out_free;
    logic                 pop;
    t_step8               step;

    assign out_free = !r_out_valid || !i_out_stall;
    assign step     = grain_step8(r_nfsr, r_lfsr, r_state == ST_INIT);

    // next-state and datapath selection
    always_comb begin
        n_state     = r_state;
        n_nfsr      = r_nfsr;
        n_lfsr      = r_lfsr;
        n_round     = r_round;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        pop         = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    if (i_job.restart) begin
                        n_nfsr  = i_cfg.key;
                        n_lfsr  = {{(KEY_BITS - IV_BITS){1'b1}}, i_cfg.iv};
                        n_round = '0;
                        n_state = ST_INIT;
                    end else if (out_free) begin
                        pop = 1'b1;
                    end
                end
            end
            ST_INIT: begin
                n_nfsr  = step.nfsr;
                n_lfsr  = step.lfsr;
                n_round = r_round + 1'b1;
                if (r_round == ROUND_LAST) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    pop     = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // keystream byte for the job at the head of the queue
        if (pop) begin
            n_nfsr      = step.nfsr;
            n_lfsr      = step.lfsr;
            n_out_valid = 1'b1;
            n_out_data  = i_job.data ^ step.ks;
            n_out_last  = i_job.last;
        end
    end

    // state, shift registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_nfsr      <= '0;
            r_lfsr      <= '0;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_nfsr      <= n_nfsr;
            r_lfsr      <= n_lfsr;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign o_job_pop   = pop;
    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_out_data;
    assign o_out_last  = r_out_last;

endmodule

[rtl/core/grain_v1_byte_stream_cipher_unit.sv]
// top level of the grain v1 byte stream cipher with its configuration registers
//
// Grain v1 with an 80-bit key and 64-bit IV; each byte is XORed with the next
// eight keystream bits, the first in the LSB, so encryption and decryption
// are the same transaction. Incoming bytes enter a QUEUE_DEPTH-entry queue and
// the engine behind it produces eight keystream bits per cycle, so plain
// bytes stream at one per cycle while the output is not stalled. A byte
// with restart set first reloads key and IV, then runs the 160-round
// initialization at eight rounds per cycle, then emits its own byte. A
// plain byte through an empty queue is registered in the queue and then in
// the output register. Key and IV writes take effect at the next restart;
// before any restart the keystream comes from the all-zero reset state.
// Index 3 on the configuration port is ignored.
module grain_v1_byte_stream_cipher_unit import gbsc_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [BYTE_BITS-1:0] i_data_in,
    input  logic                 i_restart,
    input  logic                 i_in_last,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [BYTE_BITS-1:0] o_data_out,
    output logic                 o_out_last
);

    logic [63:0] r_key_low;
    logic [15:0] r_key_high;
    logic [63:0] r_iv_value;
    t_cfg        cfg;
    logic        job_valid;
    t_job        job;
    logic        job_pop;

    assign o_cfg_ready = 1'b1;

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_iv_value <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                CFG_KEY_HIGH: r_key_high <= i_cfg_data[15:0];
                CFG_IV_VALUE: r_iv_value <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    always_comb begin
        cfg.key = {r_key_high, r_key_low};
        cfg.iv  = r_iv_value;
    end

    gbsc_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_in   (i_data_in),
        .i_restart   (i_restart),
        .i_in_last   (i_in_last),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    gbsc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_data_out  (o_data_out),
        .o_out_last  (o_out_last)
    );

endmodule

[rtl/core/gbsc_checker.sv]
// port-level checks on the cipher unit, bound to the top level
module gbsc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_data_out,
    input logic       o_out_last
);

    logic [7:0] r_pending;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = o_out_valid && !i_out_stall;

    // transactions accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + {7'd0, in_xfer} - {7'd0, out_xfer};
        end
    end

    // a result never appears without an accepted byte behind it
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_pending != 8'd0))
        else $error("output transaction without a pending input");

    // output register is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

    // stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output valid dropped under stall");

    // stalled result keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(o_data_out) && $stable(o_out_last)))
        else $error("output payload changed under stall");

endmodule

bind grain_v1_byte_stream_cipher_unit gbsc_checker u_gbsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_data_out  (o_data_out),
    .o_out_last  (o_out_last)
);
